// ===== hdl/voxel_cube_layer_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for voxel_cube_layer_engine_top
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef VOXEL_CUBE_LAYER_ENGINE_TOP_ASSERT_SVH
`define VOXEL_CUBE_LAYER_ENGINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VCLE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VCLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/vcle_pkg.sv =====
// ----------------------------------------------------------------------------
// vcle_pkg
// Codes, control word layout and microprogram of the voxel cube layer engine.
// ----------------------------------------------------------------------------
package vcle_pkg;

   // Request type codes
   localparam logic [1:0] REQ_FILL  = 2'd0;
   localparam logic [1:0] REQ_SHIFT = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_SIDE = 2'd1;
   localparam logic [1:0] STAT_RANGE    = 2'd2;

   // Orientation codes (stored x, y, z from frame x, y, z; M mirrors)
   localparam logic [3:0] ORIENT_X_Y_Z    = 4'd0;
   localparam logic [3:0] ORIENT_X_Y_MZ   = 4'd1;
   localparam logic [3:0] ORIENT_X_Z_Y    = 4'd2;
   localparam logic [3:0] ORIENT_X_MZ_Y   = 4'd3;
   localparam logic [3:0] ORIENT_Z_X_Y    = 4'd4;
   localparam logic [3:0] ORIENT_MZ_X_Y   = 4'd5;
   localparam logic [3:0] ORIENT_MX_MY_Z  = 4'd6;
   localparam logic [3:0] ORIENT_X_MY_MZ  = 4'd7;
   localparam logic [3:0] ORIENT_MX_MY_MZ = 4'd8;

   // Work class of an accepted request
   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_FILL,
      CLS_SHIFT,
      CLS_CLEAR,
      CLS_READ
   } req_class_type;

   // Control word fields
   typedef enum logic [1:0] {
      MEM_IDLE,
      MEM_READ,
      MEM_WRITE
   } mem_op_type;

   typedef enum logic [1:0] {
      ADDR_SCAN,
      ADDR_SCAN_BELOW,
      ADDR_POINT,
      ADDR_CLR
   } addr_sel_type;

   typedef enum logic [1:0] {
      WDATA_FILL,
      WDATA_SHIFT,
      WDATA_ZERO
   } wdata_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_RESET,
      CNT_STEP_XY,
      CNT_STEP_CLR
   } cnt_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_DISPATCH,
      JMP_LOOP_XY,
      JMP_LOOP_CLR,
      JMP_WAIT_OUT
   } jump_type;

   typedef logic [3:0] upc_type;

   typedef struct packed {
      logic          accept;
      mem_op_type    mem_op;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      cnt_op_type    cnt_op;
      jump_type      jump;
      upc_type       target;
   } ctrl_word_type;

   // Program step addresses
   localparam upc_type STEP_IDLE      = 4'd0;
   localparam upc_type STEP_FILL      = 4'd1;
   localparam upc_type STEP_FILL_END  = 4'd2;
   localparam upc_type STEP_SHIFT_RD  = 4'd3;
   localparam upc_type STEP_SHIFT_WR  = 4'd4;
   localparam upc_type STEP_SHIFT_END = 4'd5;
   localparam upc_type STEP_CLEAR     = 4'd6;
   localparam upc_type STEP_CLEAR_END = 4'd7;
   localparam upc_type STEP_READ      = 4'd8;
   localparam upc_type STEP_FIN       = 4'd9;
   localparam upc_type STEP_BOOT      = 4'd10;
   localparam upc_type STEP_BOOT_END  = 4'd11;

   localparam ctrl_word_type CW_NOP = '{
      accept:    1'b0,
      mem_op:    MEM_IDLE,
      addr_sel:  ADDR_CLR,
      wdata_sel: WDATA_ZERO,
      cnt_op:    CNT_HOLD,
      jump:      JMP_GOTO,
      target:    STEP_IDLE
   };

   // Microprogram read-only table: one control word per step
   function automatic ctrl_word_type ucode_rom(input upc_type pc);
      ctrl_word_type cw;
      cw = CW_NOP;
      unique case (pc)
         STEP_IDLE: begin
            cw.accept = 1'b1;
            cw.cnt_op = CNT_RESET;
            cw.jump   = JMP_DISPATCH;
         end
         STEP_FILL: begin
            cw.mem_op    = MEM_WRITE;
            cw.addr_sel  = ADDR_SCAN;
            cw.wdata_sel = WDATA_FILL;
            cw.cnt_op    = CNT_STEP_XY;
            cw.jump      = JMP_LOOP_XY;
            cw.target    = STEP_FILL;
         end
         STEP_FILL_END: begin
            cw.target = STEP_FIN;
         end
         STEP_SHIFT_RD: begin
            cw.mem_op   = MEM_READ;
            cw.addr_sel = ADDR_SCAN;
            cw.jump     = JMP_NEXT;
         end
         STEP_SHIFT_WR: begin
            cw.mem_op    = MEM_WRITE;
            cw.addr_sel  = ADDR_SCAN_BELOW;
            cw.wdata_sel = WDATA_SHIFT;
            cw.cnt_op    = CNT_STEP_XY;
            cw.jump      = JMP_LOOP_XY;
            cw.target    = STEP_SHIFT_RD;
         end
         STEP_SHIFT_END: begin
            cw.target = STEP_FIN;
         end
         STEP_CLEAR: begin
            cw.mem_op = MEM_WRITE;
            cw.cnt_op = CNT_STEP_CLR;
            cw.jump   = JMP_LOOP_CLR;
            cw.target = STEP_CLEAR;
         end
         STEP_CLEAR_END: begin
            cw.target = STEP_FIN;
         end
         STEP_READ: begin
            cw.mem_op   = MEM_READ;
            cw.addr_sel = ADDR_POINT;
            cw.jump     = JMP_NEXT;
         end
         STEP_FIN: begin
            cw.jump   = JMP_WAIT_OUT;
            cw.target = STEP_IDLE;
         end
         STEP_BOOT: begin
            cw.mem_op = MEM_WRITE;
            cw.cnt_op = CNT_STEP_CLR;
            cw.jump   = JMP_LOOP_CLR;
            cw.target = STEP_BOOT;
         end
         STEP_BOOT_END: begin
            cw.target = STEP_IDLE;
         end
         default: begin
            cw = CW_NOP;
         end
      endcase
      return cw;
   endfunction

   // Entry step of each request class
   function automatic upc_type dispatch(input req_class_type cls);
      upc_type pc;
      unique case (cls)
         CLS_FILL:  pc = STEP_FILL;
         CLS_SHIFT: pc = STEP_SHIFT_RD;
         CLS_CLEAR: pc = STEP_CLEAR;
         CLS_READ:  pc = STEP_READ;
         default:   pc = STEP_FIN;
      endcase
      return pc;
   endfunction

endpackage

// ===== hdl/voxel_cube_layer_engine_top.sv =====
// ----------------------------------------------------------------------------
// voxel_cube_layer_engine_top: one-bit voxel store with layer operations
// Fill and shift scan the layer (shift reads, then writes, each voxel), clear
// scans the store, read takes one voxel, a rejected request goes to the finish
// step. The next request is taken only after the result is loaded, so the scan
// loop over the single store port sets throughput. After reset a clearing pass
// zeroes the store; requests are held off, config writes are taken.
// ----------------------------------------------------------------------------
`include "voxel_cube_layer_engine_top_assert.svh"

module voxel_cube_layer_engine_top #(
   parameter int MAX_EDGE = 8
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [2:0] req_layer,
   input  logic [3:0] req_side,
   input  logic       req_bit_value,
   input  logic [2:0] req_read_x,
   input  logic [2:0] req_read_y,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_voxel_bit,
   output logic [1:0] rsp_status,
   // configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_cube_size
);
   import vcle_pkg::*;

   localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_EDGE);
   localparam int EW    = $clog2(MAX_EDGE + 1);

   // Map frame coordinates onto a store index
   function automatic logic [AW-1:0] locate(
      input logic [CW-1:0] x,
      input logic [CW-1:0] y,
      input logic [CW-1:0] z,
      input logic [3:0]    side,
      input logic [CW-1:0] top
   );
      logic [CW-1:0] sx;
      logic [CW-1:0] sy;
      logic [CW-1:0] sz;
      sx = x;
      sy = y;
      sz = z;
      unique case (side)
         ORIENT_X_Y_Z: begin
         end
         ORIENT_X_Y_MZ: begin
            sz = top - z;
         end
         ORIENT_X_Z_Y: begin
            sy = z;
            sz = y;
         end
         ORIENT_X_MZ_Y: begin
            sy = top - z;
            sz = y;
         end
         ORIENT_Z_X_Y: begin
            sx = z;
            sy = x;
            sz = y;
         end
         ORIENT_MZ_X_Y: begin
            sx = top - z;
            sy = x;
            sz = y;
         end
         ORIENT_MX_MY_Z: begin
            sx = top - x;
            sy = top - y;
         end
         ORIENT_X_MY_MZ: begin
            sy = top - y;
            sz = top - z;
         end
         default: begin
            sx = top - x;
            sy = top - y;
            sz = top - z;
         end
      endcase
      return AW'(sx) * AW'(MAX_EDGE * MAX_EDGE) + AW'(sy) * AW'(MAX_EDGE) + AW'(sz);
   endfunction

   // Sequencer and datapath state
   upc_type        upc_ff, upc_in;
   ctrl_word_type  cw;
   logic [3:0]     csr_cube_size_ff;
   req_class_type  class_ff, class_in;
   logic [1:0]     status_ff, status_in;
   logic [CW-1:0]  z_ff, rx_ff, ry_ff;
   logic [3:0]     side_ff;
   logic           bit_ff;
   logic [CW-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           rd_ff;
   logic           rsp_valid_ff;
   logic           rsp_voxel_bit_ff;
   logic [1:0]     rsp_status_ff;

   logic           store_mem [DEPTH];

   logic [EW-1:0]  cube_edge;
   logic [CW-1:0]  edge_top;
   logic           req_take;
   logic           xy_last;
   logic           clr_last;
   logic           slot_free;
   logic           mem_we;
   logic           mem_re;
   logic [AW-1:0]  mem_addr;
   logic           mem_wdata;

   // Fetch the control word of the current step
   assign cw = ucode_rom(upc_ff);

   // Effective edge and its last coordinate
   assign cube_edge = (32'(csr_cube_size_ff) > MAX_EDGE) ? EW'(MAX_EDGE)
                                                          : EW'(csr_cube_size_ff);
   assign edge_top  = CW'(cube_edge - EW'(1));

   // Handshakes
   assign req_stall = ~cw.accept;
   assign req_take  = req_valid & cw.accept;
   assign csr_ready = 1'b1;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_voxel_bit = rsp_voxel_bit_ff;
   assign rsp_status    = rsp_status_ff;

   // Classify an incoming request
   always_comb begin
      class_in  = CLS_NONE;
      status_in = STAT_OK;
      priority if (req_type == REQ_CLEAR) begin
         class_in = CLS_CLEAR;
      end else if (req_side > ORIENT_MX_MY_MZ) begin
         status_in = STAT_BAD_SIDE;
      end else if (32'(req_layer) >= 32'(cube_edge)) begin
         status_in = STAT_RANGE;
      end else if (req_type == REQ_FILL) begin
         class_in = CLS_FILL;
      end else if (req_type == REQ_SHIFT) begin
         if (req_layer == 3'd0) begin
            status_in = STAT_RANGE;
         end else begin
            class_in = CLS_SHIFT;
         end
      end else if ((32'(req_read_x) >= 32'(cube_edge)) ||
                   (32'(req_read_y) >= 32'(cube_edge))) begin
         status_in = STAT_RANGE;
      end else begin
         class_in = CLS_READ;
      end
   end

   // Loop end flags
   assign xy_last  = (cx_ff == edge_top) && (cy_ff == edge_top);
   assign clr_last = (clr_ff == AW'(DEPTH - 1));

   // Next step of the sequencer
   always_comb begin
      unique case (cw.jump)
         JMP_NEXT:     upc_in = upc_ff + 4'd1;
         JMP_GOTO:     upc_in = cw.target;
         JMP_DISPATCH: upc_in = req_take ? dispatch(class_in) : upc_ff;
         JMP_LOOP_XY:  upc_in = xy_last ? upc_ff + 4'd1 : cw.target;
         JMP_LOOP_CLR: upc_in = clr_last ? upc_ff + 4'd1 : cw.target;
         JMP_WAIT_OUT: upc_in = slot_free ? cw.target : upc_ff;
         default:      upc_in = STEP_IDLE;
      endcase
   end

   // Scan and clear counters
   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      clr_in = clr_ff;
      unique case (cw.cnt_op)
         CNT_RESET: begin
            cx_in  = '0;
            cy_in  = '0;
            clr_in = '0;
         end
         CNT_STEP_XY: begin
            if (cy_ff == edge_top) begin
               cy_in = '0;
               cx_in = cx_ff + CW'(1);
            end else begin
               cy_in = cy_ff + CW'(1);
            end
         end
         CNT_STEP_CLR: begin
            clr_in = clr_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   // Store address and write data
   always_comb begin
      unique case (cw.addr_sel)
         ADDR_SCAN:       mem_addr = locate(cx_ff, cy_ff, z_ff, side_ff, edge_top);
         ADDR_SCAN_BELOW: mem_addr = locate(cx_ff, cy_ff, z_ff - CW'(1), side_ff,
                                            edge_top);
         ADDR_POINT:      mem_addr = locate(rx_ff, ry_ff, z_ff, side_ff, edge_top);
         default:         mem_addr = clr_ff;
      endcase
   end

   always_comb begin
      unique case (cw.wdata_sel)
         WDATA_FILL:  mem_wdata = bit_ff;
         WDATA_SHIFT: mem_wdata = rd_ff ^ bit_ff;
         default:     mem_wdata = 1'b0;
      endcase
   end

   assign mem_we = (cw.mem_op == MEM_WRITE);
   assign mem_re = (cw.mem_op == MEM_READ);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff           <= STEP_BOOT;
         cx_ff            <= '0;
         cy_ff            <= '0;
         clr_ff           <= '0;
         csr_cube_size_ff <= 4'd8;
         rsp_valid_ff     <= 1'b0;
         class_ff         <= CLS_NONE;
      end else begin
         upc_ff <= upc_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         clr_ff <= clr_in;
         if (csr_valid && csr_ready) begin
            csr_cube_size_ff <= csr_cube_size;
         end
         if (req_take) begin
            class_ff <= class_in;
         end
         // load the result beat at the finish step, drop it once taken
         if ((cw.jump == JMP_WAIT_OUT) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         status_ff <= status_in;
         z_ff      <= CW'(req_layer);
         rx_ff     <= CW'(req_read_x);
         ry_ff     <= CW'(req_read_y);
         side_ff   <= req_side;
         bit_ff    <= req_bit_value;
      end
      if ((cw.jump == JMP_WAIT_OUT) && slot_free) begin
         rsp_voxel_bit_ff <= (class_ff == CLS_READ) ? rd_ff : 1'b0;
         rsp_status_ff    <= status_ff;
      end
   end

   // Voxel store, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= store_mem[mem_addr];
      end
   end

   // Checks
   `VCLE_ASSERT_SAME(a_write_needs_ok, mem_we && (cw.wdata_sel != WDATA_ZERO), status_ff == STAT_OK, "store written by a rejected request")
   `VCLE_ASSERT_SAME(a_scan_in_cube, cw.cnt_op == CNT_STEP_XY, (cx_ff <= edge_top) && (cy_ff <= edge_top), "scan counter left the cube")
   `VCLE_ASSERT_NEXT(a_rsp_from_fin, !rsp_valid_ff, !rsp_valid_ff || ($past(upc_ff) == STEP_FIN), "result beat raised outside the finish step")
   `VCLE_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, upc_ff != STEP_IDLE, "accepted request did not start work")

endmodule

// ===== tb/sv/voxel_cube_checker.sv =====
// ----------------------------------------------------------------------------
// voxel_cube_checker: result checker for the voxel cube layer engine
// Watches the request, result and register channels. Keeps its own copy of
// the voxel store and the cube edge, works out the result of every accepted
// request beat, and compares each result beat field by field in order.
// ----------------------------------------------------------------------------
module voxel_cube_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [2:0] req_layer,
   input  logic [3:0] req_side,
   input  logic       req_bit_value,
   input  logic [2:0] req_read_x,
   input  logic [2:0] req_read_y,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_voxel_bit,
   input  logic [1:0] rsp_status,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [3:0] csr_cube_size,
   output int         fail_count,
   output int         results_pending,
   output int         results_checked
);
   import vcle_pkg::*;

   localparam int EDGE_MAX = 8;

   typedef struct packed {
      logic       voxel_bit;
      logic [1:0] status;
   } voxel_result_type;

   bit               voxel_copy[EDGE_MAX * EDGE_MAX * EDGE_MAX];
   logic [3:0]       cube_edge;
   voxel_result_type expected_voxel_results[$];

   // Map frame coordinates of one orientation onto a store index
   function automatic int store_index(input int x, input int y, input int z,
                                      input logic [3:0] side, input int e);
      int sx;
      int sy;
      int sz;
      sx = x;
      sy = y;
      sz = z;
      unique case (side)
         ORIENT_X_Y_Z: ;
         ORIENT_X_Y_MZ: sz = e - 1 - z;
         ORIENT_X_Z_Y: begin
            sy = z;
            sz = y;
         end
         ORIENT_X_MZ_Y: begin
            sy = e - 1 - z;
            sz = y;
         end
         ORIENT_Z_X_Y: begin
            sx = z;
            sy = x;
            sz = y;
         end
         ORIENT_MZ_X_Y: begin
            sx = e - 1 - z;
            sy = x;
            sz = y;
         end
         ORIENT_MX_MY_Z: begin
            sx = e - 1 - x;
            sy = e - 1 - y;
         end
         ORIENT_X_MY_MZ: begin
            sy = e - 1 - y;
            sz = e - 1 - z;
         end
         default: begin
            sx = e - 1 - x;
            sy = e - 1 - y;
            sz = e - 1 - z;
         end
      endcase
      return (sx * EDGE_MAX + sy) * EDGE_MAX + sz;
   endfunction

   // Apply one request to the store copy and return the result it gives
   function automatic voxel_result_type apply_layer_request(
         input logic [1:0] kind, input logic [2:0] layer, input logic [3:0] side,
         input logic flag, input logic [2:0] rx, input logic [2:0] ry);
      voxel_result_type res;
      int               e;
      int               z;
      bit               v;
      res.voxel_bit = 1'b0;
      res.status    = STAT_OK;
      e = (cube_edge > EDGE_MAX) ? EDGE_MAX : int'(cube_edge);
      z = int'(layer);
      if (kind == REQ_CLEAR) begin
         foreach (voxel_copy[i]) voxel_copy[i] = 1'b0;
      end else if (side > ORIENT_MX_MY_MZ) begin
         res.status = STAT_BAD_SIDE;
      end else if (z >= e) begin
         res.status = STAT_RANGE;
      end else if (kind == REQ_FILL) begin
         for (int x = 0; x < e; x++)
            for (int y = 0; y < e; y++)
               voxel_copy[store_index(x, y, z, side, e)] = flag;
      end else if (kind == REQ_SHIFT) begin
         if (z == 0) begin
            res.status = STAT_RANGE;
         end else begin
            for (int x = 0; x < e; x++)
               for (int y = 0; y < e; y++) begin
                  v = voxel_copy[store_index(x, y, z, side, e)];
                  voxel_copy[store_index(x, y, z - 1, side, e)] = v ^ flag;
               end
         end
      end else if (int'(rx) >= e || int'(ry) >= e) begin
         res.status = STAT_RANGE;
      end else begin
         res.voxel_bit = voxel_copy[store_index(int'(rx), int'(ry), z, side, e)];
      end
      return res;
   endfunction

   // Track register writes, predict on request beats, compare result beats
   always @(posedge clock) begin
      voxel_result_type want;
      if (reset) begin
         foreach (voxel_copy[i]) voxel_copy[i] = 1'b0;
         cube_edge = 4'd8;
         expected_voxel_results.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (csr_valid && csr_ready)
            cube_edge = csr_cube_size;
         // compare first: a result beat never belongs to a request taken now
         if (rsp_valid && !rsp_stall) begin
            if (expected_voxel_results.size() == 0) begin
               $display("%0t: unexpected result beat, voxel_bit %b status %0d",
                        $time, rsp_voxel_bit, rsp_status);
               fail_count++;
            end else begin
               want = expected_voxel_results.pop_front();
               results_checked++;
               if (rsp_voxel_bit !== want.voxel_bit || rsp_status !== want.status) begin
                  if (rsp_voxel_bit !== want.voxel_bit)
                     $display("%0t: voxel_bit mismatch, expected %b actual %b",
                              $time, want.voxel_bit, rsp_voxel_bit);
                  if (rsp_status !== want.status)
                     $display("%0t: status mismatch, expected %0d actual %0d",
                              $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_voxel_results.push_back(apply_layer_request(req_type, req_layer,
               req_side, req_bit_value, req_read_x, req_read_y));
      end
      results_pending = expected_voxel_results.size();
   end

   // Flag results still owed at the end of the run
   final begin
      if (expected_voxel_results.size() != 0)
         $display("%0t: %0d expected results never arrived",
                  $time, expected_voxel_results.size());
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the voxel cube layer engine
// Drives a short directed sequence over every request type, orientation and
// corner case, then random requests under a series of cube edges and idle
// mixes, with one long result hold-off. The checker module does the compare.
// ----------------------------------------------------------------------------
module testbench;
   import vcle_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PHASE_ITEMS     = 120;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_type;
   logic [2:0] req_layer;
   logic [3:0] req_side;
   logic       req_bit_value;
   logic [2:0] req_read_x;
   logic [2:0] req_read_y;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_voxel_bit;
   logic [1:0] rsp_status;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_cube_size;

   int         fail_count;
   int         results_pending;
   int         results_checked;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         requests_sent;
   int         edge_writes;
   int         quiet_cycles;
   logic [3:0] edge_in_use;
   logic       hold_off_req;

   logic [3:0] phase_edges[9] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7, 4'd6};
   int         send_mix[3]    = '{17, 71, 0};
   int         recv_mix[3]    = '{71, 17, 0};

   voxel_cube_layer_engine_top #(.MAX_EDGE(8)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_layer     (req_layer),
      .req_side      (req_side),
      .req_bit_value (req_bit_value),
      .req_read_x    (req_read_x),
      .req_read_y    (req_read_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_voxel_bit (rsp_voxel_bit),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_cube_size (csr_cube_size)
   );

   voxel_cube_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_layer       (req_layer),
      .req_side        (req_side),
      .req_bit_value   (req_bit_value),
      .req_read_x      (req_read_x),
      .req_read_y      (req_read_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_voxel_bit   (rsp_voxel_bit),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_cube_size   (csr_cube_size),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   // Clock: period 8
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Offer one request beat, idling first at random, and hold it until taken
   task automatic send_request(input logic [1:0] kind, input logic [2:0] layer,
                               input logic [3:0] side, input logic flag,
                               input logic [2:0] rx, input logic [2:0] ry);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_type      = kind;
      req_layer     = layer;
      req_side      = side;
      req_bit_value = flag;
      req_read_x    = rx;
      req_read_y    = ry;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // Write the cube edge once every owed result has come back
   task automatic set_cube_edge(input logic [3:0] size);
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      csr_valid     = 1'b1;
      csr_cube_size = size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid   = 1'b0;
      edge_in_use = size;
      edge_writes++;
   endtask

   // Pick a coordinate, mostly inside the edge in use
   function automatic logic [2:0] pick_coord(input int e);
      if (e > 0 && $urandom_range(99) < 85)
         return 3'($urandom_range(e - 1));
      return 3'($urandom_range(7));
   endfunction

   // Random request: mostly valid orientations and in-range coordinates
   task automatic send_random_request();
      int         e;
      int         roll;
      logic [1:0] kind;
      logic [3:0] side;
      e    = (edge_in_use > 8) ? 8 : int'(edge_in_use);
      roll = $urandom_range(99);
      if (roll < 30)
         kind = REQ_FILL;
      else if (roll < 60)
         kind = REQ_SHIFT;
      else if (roll < 64)
         kind = REQ_CLEAR;
      else
         kind = REQ_READ;
      if ($urandom_range(99) < 90)
         side = 4'($urandom_range(8));
      else
         side = 4'($urandom_range(15, 9));
      send_request(kind, pick_coord(e), side, 1'($urandom_range(1)),
                   pick_coord(e), pick_coord(e));
   endtask

   // Result side: random stall, or one long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_FILL;
      req_layer     = 3'd0;
      req_side      = ORIENT_X_Y_Z;
      req_bit_value = 1'b0;
      req_read_x    = 3'd0;
      req_read_y    = 3'd0;
      csr_valid     = 1'b0;
      csr_cube_size = 4'd8;
      hold_off_req  = 1'b0;
      requests_sent = 0;
      edge_writes   = 0;
      edge_in_use   = 4'd8;
      send_idle_pct = send_mix[0];
      recv_idle_pct = recv_mix[0];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: full edge, every request type and all orientations but MZ_X_Y
      set_cube_edge(4'd8);
      send_request(REQ_FILL,  3'd7, ORIENT_X_Y_Z,    1'b1, 3'd0, 3'd0);
      send_request(REQ_FILL,  3'd0, ORIENT_Z_X_Y,    1'b1, 3'd0, 3'd0);
      send_request(REQ_READ,  3'd7, ORIENT_X_Y_Z,    1'b0, 3'd7, 3'd7);
      send_request(REQ_READ,  3'd0, ORIENT_MX_MY_MZ, 1'b0, 3'd0, 3'd0);
      send_request(REQ_SHIFT, 3'd7, ORIENT_X_Y_MZ,   1'b1, 3'd0, 3'd0);
      // shift of the bottom layer has nothing below it
      send_request(REQ_SHIFT, 3'd0, ORIENT_X_Y_Z,    1'b0, 3'd0, 3'd0);
      send_request(REQ_FILL,  3'd2, ORIENT_X_MZ_Y,   1'b1, 3'd0, 3'd0);
      send_request(REQ_SHIFT, 3'd4, ORIENT_MX_MY_Z,  1'b0, 3'd0, 3'd0);
      send_request(REQ_SHIFT, 3'd6, ORIENT_X_MY_MZ,  1'b1, 3'd0, 3'd0);
      send_request(REQ_READ,  3'd1, ORIENT_X_Z_Y,    1'b0, 3'd6, 3'd4);
      // invalid orientations on fill, read and shift
      send_request(REQ_FILL,  3'd1, 4'd9,            1'b1, 3'd0, 3'd0);
      send_request(REQ_READ,  3'd0, 4'd15,           1'b0, 3'd0, 3'd0);
      send_request(REQ_SHIFT, 3'd5, 4'd12,           1'b0, 3'd0, 3'd0);
      // clear ignores every other field
      send_request(REQ_CLEAR, 3'd7, 4'd15,           1'b1, 3'd7, 3'd7);
      send_request(REQ_READ,  3'd7, ORIENT_X_Y_Z,    1'b0, 3'd7, 3'd7);

      // directed: small edge, layer and coordinates out of range
      set_cube_edge(4'd3);
      send_request(REQ_FILL,  3'd3, ORIENT_X_Y_Z,    1'b1, 3'd0, 3'd0);
      send_request(REQ_FILL,  3'd2, ORIENT_MX_MY_MZ, 1'b1, 3'd0, 3'd0);
      send_request(REQ_READ,  3'd0, ORIENT_X_Y_Z,    1'b0, 3'd3, 3'd0);
      send_request(REQ_READ,  3'd0, ORIENT_X_Y_Z,    1'b0, 3'd0, 3'd7);
      send_request(REQ_READ,  3'd0, ORIENT_X_Y_Z,    1'b0, 3'd2, 3'd2);

      // directed: empty cube, then oversized edge
      set_cube_edge(4'd0);
      send_request(REQ_FILL,  3'd0, ORIENT_X_Y_Z,    1'b1, 3'd0, 3'd0);
      send_request(REQ_READ,  3'd0, 4'd9,            1'b0, 3'd0, 3'd0);
      send_request(REQ_CLEAR, 3'd0, ORIENT_X_Y_Z,    1'b0, 3'd0, 3'd0);
      set_cube_edge(4'd15);
      send_request(REQ_FILL,  3'd7, ORIENT_MZ_X_Y,   1'b1, 3'd0, 3'd0);
      send_request(REQ_READ,  3'd0, ORIENT_MZ_X_Y,   1'b0, 3'd7, 3'd7);

      // random phases: one edge each, idle mix changes every three phases
      for (int phase = 0; phase < 9; phase++) begin
         set_cube_edge(phase_edges[phase]);
         send_idle_pct = send_mix[phase / 3];
         recv_idle_pct = recv_mix[phase / 3];
         // fill the block while results are held back
         if (phase == 6)
            hold_off_req = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_request();
      end

      // drain
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d requests under %0d edge writes (edges 0 to 15), %0d compared.",
               requests_sent, edge_writes, results_checked);
      $display("Idle mixes: sender 17/receiver 71, 71/17, none, plus one long hold-off.");
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
